FILE: src/lmrs_pkg.sv
// Shared types and codes for the match-and-remove event stack.
// No dependencies; every other file imports this package.
`default_nettype none

package lmrs_pkg;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_MATCH = 2'd2
    } t_status;

    localparam int unsigned KEY_BITS     = 32;
    localparam int unsigned HANDLE_FIELD = 16;
    localparam int unsigned COUNT_FIELD  = 7;

    // Controls broadcast from the top level to every cell
    typedef struct packed {
        logic cmp_en;     // latch compare result against the live key
        logic do_insert;  // apply cycle of an insert
        logic do_remove;  // apply cycle of a remove
        logic any_hit;    // some cell matched
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: src/lmrs_req_if.sv
// Request channel: valid/ready handshake with the item payload.
// Depends on lmrs_pkg for field widths.
`default_nettype none

interface lmrs_req_if import lmrs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [KEY_BITS-1:0]     key_offset;
    logic [KEY_BITS-1:0]     key_size;
    logic [HANDLE_FIELD-1:0] event_handle;

    modport source (output valid, operation, key_offset, key_size, event_handle,
                    input ready);
    modport sink   (input valid, operation, key_offset, key_size, event_handle,
                    output ready);
endinterface

`default_nettype wire

FILE: src/lmrs_rsp_if.sv
// Result channel: valid/ready handshake with the result payload.
// Depends on lmrs_pkg for field widths.
`default_nettype none

interface lmrs_rsp_if import lmrs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [HANDLE_FIELD-1:0] found_handle;
    logic [COUNT_FIELD-1:0]  entry_count;

    modport source (output valid, status, found_handle, entry_count, input ready);
    modport sink   (input valid, status, found_handle, entry_count, output ready);
endinterface

`default_nettype wire

FILE: src/lifo_match_remove_store.sv
// Match-and-remove event stack: a row of DEPTH slot cells, newest on top.
// An item is handled in two steps: at the accepting edge every cell compares its
// entry with the key; then, in the apply cycle, the hit chain through the cells
// picks the newest match, the cells above it shift down one place (or the lowest
// empty cell takes an insert) and the result is registered. The apply cycle
// waits while the result register still holds an untaken result. The input is
// ready again once the item has been applied, so a new item is not taken until
// the last one has been through the compare-then-shift pass over the cell row.
// The result register lets the next item be taken while a result waits.
// Depends on lmrs_pkg, lmrs_req_if, lmrs_rsp_if and lmrs_cell.
`default_nettype none

module lifo_match_remove_store import lmrs_pkg::*; #(
    parameter int unsigned DEPTH       = 64,
    parameter int unsigned HANDLE_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lmrs_req_if.sink   i_req,
    lmrs_rsp_if.source o_rsp
);

    localparam int unsigned HW = (HANDLE_BITS < HANDLE_FIELD) ? HANDLE_BITS : HANDLE_FIELD;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic                r_busy;
    logic                r_op;
    logic [KEY_BITS-1:0] r_offset;
    logic [KEY_BITS-1:0] r_size;
    logic [HW-1:0]       r_handle;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;

    logic                    r_out_valid;
    t_status                 r_status;
    t_status                 n_status;
    logic [HANDLE_FIELD-1:0] r_found;
    logic [HANDLE_FIELD-1:0] n_found;
    logic [COUNT_FIELD-1:0]  r_entries;

    logic      w_accept;
    logic      w_apply;
    logic      w_drain;
    t_cell_ctl w_ctl;

    logic [DEPTH-1:0]    w_valid;
    logic [KEY_BITS-1:0] w_offset [DEPTH];
    logic [KEY_BITS-1:0] w_size   [DEPTH];
    logic [HW-1:0]       w_handle [DEPTH];
    logic [DEPTH:0]      w_hit;
    logic [HW-1:0]       w_found  [DEPTH+1];

    assign i_req.ready = !r_busy;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_drain     = o_rsp.valid && o_rsp.ready;
    // Hold the apply cycle until the result register is free
    assign w_apply     = r_busy && (!r_out_valid || o_rsp.ready);

    assign w_ctl.cmp_en    = w_accept;
    assign w_ctl.do_insert = w_apply && (t_op'(r_op) == OP_INSERT);
    assign w_ctl.do_remove = w_apply && (t_op'(r_op) == OP_REMOVE);
    assign w_ctl.any_hit   = w_hit[0];

    assign w_hit[DEPTH]   = 1'b0;
    assign w_found[DEPTH] = '0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                w_up_valid;
        logic [KEY_BITS-1:0] w_up_offset;
        logic [KEY_BITS-1:0] w_up_size;
        logic [HW-1:0]       w_up_handle;
        logic                w_below_valid;

        if (gi == DEPTH - 1) begin : g_top
            assign w_up_valid  = 1'b0;
            assign w_up_offset = '0;
            assign w_up_size   = '0;
            assign w_up_handle = '0;
        end else begin : g_mid
            assign w_up_valid  = w_valid[gi+1];
            assign w_up_offset = w_offset[gi+1];
            assign w_up_size   = w_size[gi+1];
            assign w_up_handle = w_handle[gi+1];
        end

        if (gi == 0) begin : g_bottom
            assign w_below_valid = 1'b1;
        end else begin : g_upper
            assign w_below_valid = w_valid[gi-1];
        end

        lmrs_cell #(
            .HW(HW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_cmp_offset (i_req.key_offset),
            .i_cmp_size   (i_req.key_size),
            .i_wr_offset  (r_offset),
            .i_wr_size    (r_size),
            .i_wr_handle  (r_handle),
            .i_up_valid   (w_up_valid),
            .i_up_offset  (w_up_offset),
            .i_up_size    (w_up_size),
            .i_up_handle  (w_up_handle),
            .i_below_valid(w_below_valid),
            .i_hit_above  (w_hit[gi+1]),
            .o_hit_above  (w_hit[gi]),
            .i_found      (w_found[gi+1]),
            .o_found      (w_found[gi]),
            .o_valid      (w_valid[gi]),
            .o_offset     (w_offset[gi]),
            .o_size       (w_size[gi]),
            .o_handle     (w_handle[gi])
        );
    end

    // Result of the item in its apply cycle
    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_found  = '0;
        if (t_op'(r_op) == OP_INSERT) begin
            if (r_count == FULL_COUNT) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else begin
            if (w_hit[0]) begin
                n_count = r_count - CW'(1);
                n_found = HANDLE_FIELD'(w_found[0]);
            end else begin
                n_status = ST_NO_MATCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_apply) begin
                r_busy <= 1'b0;
            end
            if (w_apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (w_drain) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the item for the apply cycle; load the result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_req.operation;
            r_offset <= i_req.key_offset;
            r_size   <= i_req.key_size;
            r_handle <= i_req.event_handle[HW-1:0];
        end
        if (w_apply) begin
            r_status  <= n_status;
            r_found   <= n_found;
            r_entries <= COUNT_FIELD'(n_count);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.found_handle = r_found;
    assign o_rsp.entry_count  = r_entries;

    // Occupied cells stay packed from the bottom and match the count
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with entry count");

    a_accept_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("transfer did not start an item");

    a_apply_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply |=> r_out_valid)
        else $error("applied item did not produce a result");

    a_handle_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_DONE) |-> (r_found == '0))
        else $error("handle returned with failing status");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above depth");

endmodule

`default_nettype wire

FILE: src/lmrs_cell.sv
// One stack slot: holds an entry, compares it with the key and shifts down
// from its upper neighbor when an entry at or below it is removed. Uses lmrs_pkg.
`default_nettype none

module lmrs_cell import lmrs_pkg::*; #(
    parameter int unsigned HW = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cell_ctl           i_ctl,
    input  wire logic [KEY_BITS-1:0] i_cmp_offset,
    input  wire logic [KEY_BITS-1:0] i_cmp_size,
    input  wire logic [KEY_BITS-1:0] i_wr_offset,
    input  wire logic [KEY_BITS-1:0] i_wr_size,
    input  wire logic [HW-1:0]       i_wr_handle,
    input  wire logic                i_up_valid,
    input  wire logic [KEY_BITS-1:0] i_up_offset,
    input  wire logic [KEY_BITS-1:0] i_up_size,
    input  wire logic [HW-1:0]       i_up_handle,
    input  wire logic                i_below_valid,
    input  wire logic                i_hit_above,
    output logic                     o_hit_above,
    input  wire logic [HW-1:0]       i_found,
    output logic [HW-1:0]            o_found,
    output logic                     o_valid,
    output logic [KEY_BITS-1:0]      o_offset,
    output logic [KEY_BITS-1:0]      o_size,
    output logic [HW-1:0]            o_handle
);

    logic                r_valid;
    logic                r_match;
    logic [KEY_BITS-1:0] r_offset;
    logic [KEY_BITS-1:0] r_size;
    logic [HW-1:0]       r_handle;

    logic w_sel;
    logic w_shift;
    logic w_write;

    // This cell is the newest match when it hit and nothing above did
    assign w_sel   = r_match && !i_hit_above;
    // Cells at or above the removed slot take their upper neighbor
    assign w_shift = i_ctl.do_remove && i_ctl.any_hit && !i_hit_above;
    assign w_write = i_ctl.do_insert && !r_valid && i_below_valid;

    assign o_hit_above = i_hit_above || r_match;
    assign o_found     = i_found | (w_sel ? r_handle : '0);
    assign o_valid     = r_valid;
    assign o_offset    = r_offset;
    assign o_size      = r_size;
    assign o_handle    = r_handle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp_en) begin
                r_match <= r_valid && (r_offset == i_cmp_offset)
                                   && (r_size == i_cmp_size);
            end
            if (w_shift) begin
                r_valid <= i_up_valid;
            end else if (w_write) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_offset <= i_up_offset;
            r_size   <= i_up_size;
            r_handle <= i_up_handle;
        end else if (w_write) begin
            r_offset <= i_wr_offset;
            r_size   <= i_wr_size;
            r_handle <= i_wr_handle;
        end
    end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for lifo_match_remove_store: directed table, then random
// fill/drain/mixed traffic checked against an in-bench model of the event stack.
// Depends on lmrs_pkg, lmrs_req_if, lmrs_rsp_if and the RTL top level.

module tb_top;
    import lmrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH    = 64;
    localparam int NUM_RANDOM     = 1650;
    localparam int BLOCK_LEN      = 110;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int NUM_DIR        = 21;

    typedef enum int {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } t_mix;

    typedef struct packed {
        t_op         op;
        logic [31:0] key_offset;
        logic [31:0] key_size;
        logic [15:0] ev_handle;
    } t_event_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] found_handle;
        logic [6:0]  entry_count;
    } t_event_result;

    typedef struct packed {
        t_event_item   item;
        logic          fixed;
        t_event_result res;
    } t_dir_row;

    // Directed rows: fixed = 1 carries a result typed in by hand
    t_dir_row dir_rows [NUM_DIR] = '{
        '{'{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1,
          '{ST_NO_MATCH, 16'h0000, 7'd0}},
        '{'{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
          '{ST_DONE, 16'h0000, 7'd1}},
        '{'{OP_INSERT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1,
          '{ST_DONE, 16'h0000, 7'd2}},
        '{'{OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 16'h1234}, 1'b1,
          '{ST_DONE, 16'h0000, 7'd3}},
        '{'{OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 16'h5A5A}, 1'b1,
          '{ST_DONE, 16'h0000, 7'd4}},
        '{'{OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000}, 1'b1,
          '{ST_DONE, 16'hFFFF, 7'd3}},
        '{'{OP_INSERT, 32'h0000_0100, 32'h0000_0020, 16'hA001}, 1'b0,
          '{ST_DONE, 16'h0000, 7'd0}},
        '{'{OP_INSERT, 32'h0000_0100, 32'h0000_0020, 16'hA002}, 1'b0,
          '{ST_DONE, 16'h0000, 7'd0}},
        '{'{OP_INSERT, 32'h0000_0200, 32'h0000_0020, 16'hB000}, 1'b0,
          '{ST_DONE, 16'h0000, 7'd0}},
        '{'{OP_REMOVE, 32'h0000_0100, 32'h0000_0020, 16'h0000}, 1'b1,
          '{ST_DONE, 16'hA002, 7'd5}},
        '{'{OP_REMOVE, 32'h0000_0100, 32'h0000_0021, 16'h0000}, 1'b1,
          '{ST_NO_MATCH, 16'h0000, 7'd5}},
        '{'{OP_REMOVE, 32'h0000_0101, 32'h0000_0020, 16'h0000}, 1'b1,
          '{ST_NO_MATCH, 16'h0000, 7'd5}},
        '{'{OP_REMOVE, 32'h0000_0100, 32'h0000_0020, 16'h0000}, 1'b1,
          '{ST_DONE, 16'hA001, 7'd4}},
        '{'{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1,
          '{ST_DONE, 16'h0000, 7'd3}},
        '{'{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1,
          '{ST_NO_MATCH, 16'h0000, 7'd3}},
        '{'{OP_REMOVE, 32'h0000_0200, 32'h0000_0020, 16'h0000}, 1'b1,
          '{ST_DONE, 16'hB000, 7'd2}},
        '{'{OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000}, 1'b1,
          '{ST_DONE, 16'h1234, 7'd1}},
        '{'{OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000}, 1'b1,
          '{ST_DONE, 16'h5A5A, 7'd0}},
        '{'{OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000}, 1'b1,
          '{ST_NO_MATCH, 16'h0000, 7'd0}},
        '{'{OP_INSERT, 32'h0000_0001, 32'h8000_0000, 16'h8000}, 1'b1,
          '{ST_DONE, 16'h0000, 7'd1}},
        '{'{OP_REMOVE, 32'h0000_0001, 32'h8000_0000, 16'hFFFF}, 1'b1,
          '{ST_DONE, 16'h8000, 7'd0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    lmrs_req_if req_ch ();
    lmrs_rsp_if rsp_ch ();

    lifo_match_remove_store #(
        .DEPTH       (STACK_DEPTH),
        .HANDLE_BITS (16)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Model of the stack: slot 0 oldest, slot held-1 newest
    logic [31:0] st_offset [STACK_DEPTH];
    logic [31:0] st_size   [STACK_DEPTH];
    logic [15:0] st_handle [STACK_DEPTH];
    int          held = 0;

    t_event_result awaited_results [$];

    int  mismatches    = 0;
    int  items_sent    = 0;
    int  n_inserts     = 0;
    int  n_refused     = 0;
    int  n_hits        = 0;
    int  n_misses      = 0;
    int  peak_held     = 0;
    int  idle_cycles   = 0;
    bit  quiet         = 1'b0;
    bit  stall_request = 1'b0;

    function automatic t_event_result stack_apply(input t_event_item it);
        t_event_result r;
        int            hit_at;
        r      = '{ST_DONE, 16'h0000, 7'd0};
        hit_at = -1;
        if (it.op == OP_INSERT) begin
            n_inserts++;
            if (held >= STACK_DEPTH) begin
                r.status = ST_FULL;
                n_refused++;
            end else begin
                st_offset[held] = it.key_offset;
                st_size[held]   = it.key_size;
                st_handle[held] = it.ev_handle;
                held++;
            end
        end else begin
            // newest match wins
            for (int i = held - 1; i >= 0; i--) begin
                if (st_offset[i] == it.key_offset && st_size[i] == it.key_size) begin
                    hit_at = i;
                    break;
                end
            end
            if (hit_at < 0) begin
                r.status = ST_NO_MATCH;
                n_misses++;
            end else begin
                r.found_handle = st_handle[hit_at];
                for (int j = hit_at; j + 1 < held; j++) begin
                    st_offset[j] = st_offset[j + 1];
                    st_size[j]   = st_size[j + 1];
                    st_handle[j] = st_handle[j + 1];
                end
                held--;
                n_hits++;
            end
        end
        if (held > peak_held)
            peak_held = held;
        r.entry_count = 7'(held);
        return r;
    endfunction

    // Random item shaped by the current stack contents so removes mostly hit
    function automatic t_event_item pick_item(input t_mix mix);
        t_event_item it;
        int          ins_pct;
        int          k;
        ins_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 10 : 50;
        it.ev_handle  = 16'($urandom);
        it.key_offset = $urandom;
        it.key_size   = $urandom;
        if ($urandom_range(99) < ins_pct) begin
            it.op = OP_INSERT;
            // duplicate an existing key now and then
            if (held > 0 && $urandom_range(3) == 0) begin
                k = $urandom_range(held - 1);
                it.key_offset = st_offset[k];
                it.key_size   = st_size[k];
            end
        end else begin
            it.op = OP_REMOVE;
            if (held > 0) begin
                k = $urandom_range(held - 1);
                case ($urandom_range(9))
                    0: ;
                    1: begin
                        it.key_offset = st_offset[k];
                        it.key_size   = st_size[k] ^ (32'd1 << $urandom_range(31));
                    end
                    2: begin
                        it.key_offset = st_offset[k] ^ (32'd1 << $urandom_range(31));
                        it.key_size   = st_size[k];
                    end
                    default: begin
                        it.key_offset = st_offset[k];
                        it.key_size   = st_size[k];
                    end
                endcase
            end
        end
        return it;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("tb_top: ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic offer_item(input t_event_item it, input logic fixed,
                              input t_event_result fixed_res);
        int            gap;
        t_event_result r;
        gap = 0;
        if (!quiet)
            while ($urandom_range(99) < 23)
                gap++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= it.op;
        req_ch.key_offset   <= it.key_offset;
        req_ch.key_size     <= it.key_size;
        req_ch.event_handle <= it.ev_handle;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        // transfer taken at this edge
        r = stack_apply(it);
        awaited_results.push_back(fixed ? fixed_res : r);
        items_sent++;
    endtask

    initial begin : result_sink
        t_event_result want;
        int            hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    flag_error($sformatf("unexpected result status=%0d handle=%h count=%0d",
                               rsp_ch.status, rsp_ch.found_handle, rsp_ch.entry_count));
                end else begin
                    want = awaited_results.pop_front();
                    if (rsp_ch.status !== want.status
                            || rsp_ch.found_handle !== want.found_handle
                            || rsp_ch.entry_count !== want.entry_count)
                        flag_error($sformatf(
                            "exp status=%0d handle=%h count=%0d, got %0d %h %0d",
                            want.status, want.found_handle, want.entry_count,
                            rsp_ch.status, rsp_ch.found_handle, rsp_ch.entry_count));
                end
            end
            if (stall_request) begin
                hold_left     = HOLD_CYCLES;
                stall_request = 1'b0;
            end
            if (i_rst_n !== 1'b1) begin
                rsp_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= quiet || ($urandom_range(99) >= 23);
            end
        end
    end

    // End the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: timeout, %0d results outstanding", awaited_results.size());
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_mix mix;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= OP_INSERT;
        req_ch.key_offset   <= '0;
        req_ch.key_size     <= '0;
        req_ch.event_handle <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            offer_item(dir_rows[r].item, dir_rows[r].fixed, dir_rows[r].res);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            mix   = t_mix'((n / BLOCK_LEN) % 3);
            quiet = (n >= 800 && n < 1100);
            // hold off the result side while items keep coming
            if (n == 400)
                stall_request = 1'b1;
            offer_item(pick_item(mix), 1'b0, '{ST_DONE, 16'h0000, 7'd0});
        end
        req_ch.valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d items: %0d inserts (%0d refused on full), %0d removes",
                 items_sent, n_inserts, n_refused, n_hits + n_misses);
        $display("tb_top: %0d removes hit, %0d missed, peak occupancy %0d, %0d mismatches",
                 n_hits, n_misses, peak_held, mismatches);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
src/lmrs_pkg.sv
src/lmrs_req_if.sv
src/lmrs_rsp_if.sv
src/lmrs_cell.sv
src/lifo_match_remove_store.sv
dv/tb_top.sv
